// ===== rtl/core/imf_pkg.sv =====
// ----------------------------------------------------------------------------
// imf_pkg: shared types and constants of the multicast ingress filter
// Verdict codes, option-walk codes and the packet summary record that the
// parser hands to the verdict stage.
// ----------------------------------------------------------------------------
`default_nettype none

package imf_pkg;

  localparam logic [15:0] HDR_BYTES      = 16'd40;
  localparam logic [15:0] HBH_MIN_BYTES  = 16'd42;
  localparam logic [15:0] CNT_MAX        = 16'hffff;
  localparam logic [3:0]  SCOPE_MASK     = 4'hc;
  localparam logic [7:0]  MCAST_PREFIX   = 8'hff;
  localparam logic [9:0]  LLOCAL_PREFIX  = 10'h3fa;
  localparam logic [7:0]  NH_HOP_BY_HOP  = 8'd0;
  localparam logic [7:0]  OPT_PAD1       = 8'd0;
  localparam logic [7:0]  OPT_PADN       = 8'd1;
  localparam logic [16:0] EXT_UNIT       = 17'd8;

  // Byte offsets in the IPv6 header
  localparam logic [15:0] IDX_NEXT_HDR   = 16'd6;
  localparam logic [15:0] IDX_HOP_LIMIT  = 16'd7;
  localparam logic [15:0] IDX_SRC_HI     = 16'd8;
  localparam logic [15:0] IDX_SRC_LO     = 16'd16;
  localparam logic [15:0] IDX_DST_HI     = 16'd24;
  localparam logic [15:0] IDX_DST_LO     = 16'd32;
  localparam logic [15:0] IDX_EXT_LEN    = 16'd41;
  localparam logic [15:0] IDX_OPTIONS    = 16'd42;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [3:0] {
    VERDICT_FORWARD   = 4'd0,
    VERDICT_SHORT     = 4'd1,
    VERDICT_HOP       = 4'd2,
    VERDICT_DST_UCAST = 4'd3,
    VERDICT_BAD_SRC   = 4'd4,
    VERDICT_SCOPE     = 4'd5,
    VERDICT_EXT_TRUNC = 4'd6,
    VERDICT_EXT_MALF  = 4'd7,
    VERDICT_OPT_DROP  = 4'd8
  } verdict_t;

  typedef enum logic [1:0] {
    OPT_PH_TYPE        = 2'd0,
    OPT_PH_LEN_PLAIN   = 2'd1,
    OPT_PH_LEN_DISCARD = 2'd2,
    OPT_PH_SKIP        = 2'd3
  } opt_phase_t;

  typedef enum logic [1:0] {
    OPT_ERR_NONE      = 2'd0,
    OPT_ERR_MALFORMED = 2'd1,
    OPT_ERR_DISCARD   = 2'd2
  } opt_err_t;

  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  hop_limit;
    logic [7:0]  next_header;
    logic [7:0]  ext_len;
    opt_err_t    opt_err;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [7:0]  port;
  } pkt_rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/imf_parser.sv =====
// ----------------------------------------------------------------------------
// imf_parser: byte-stream front end
// Counts bytes, captures header fields, walks hop-by-hop options and emits
// one packet summary on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_vld,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [7:0]        ingress_port,
  output imf_pkg::pkt_rec_t      rec,
  output logic                   rec_vld
);
  import imf_pkg::*;

  logic [15:0] count_r, count_nxt, count_inc;
  logic [7:0]  nh_r, nh_nxt;
  logic [7:0]  hop_r, hop_nxt;
  logic [7:0]  ext_r, ext_nxt;
  logic [7:0]  port_r, port_nxt;
  logic [63:0] src_hi_r, src_hi_nxt, src_lo_r, src_lo_nxt;
  logic [63:0] dst_hi_r, dst_hi_nxt, dst_lo_r, dst_lo_nxt;
  logic [10:0] ol_r, ol_nxt;
  logic [7:0]  skip_r, skip_nxt, skip_dec;
  opt_phase_t  phase_r, phase_nxt;
  opt_err_t    err_r, err_nxt;
  logic [8:0]  need;

  assign count_inc = (count_r == CNT_MAX) ? count_r : count_r + 16'd1;
  assign need      = {1'b0, data_byte} + 9'd2;
  assign skip_dec  = (skip_r != 8'd0) ? skip_r - 8'd1 : 8'd0;

  always_comb begin
    count_nxt  = count_r;
    nh_nxt     = nh_r;
    hop_nxt    = hop_r;
    ext_nxt    = ext_r;
    port_nxt   = port_r;
    src_hi_nxt = src_hi_r;
    src_lo_nxt = src_lo_r;
    dst_hi_nxt = dst_hi_r;
    dst_lo_nxt = dst_lo_r;
    ol_nxt     = ol_r;
    skip_nxt   = skip_r;
    phase_nxt  = phase_r;
    err_nxt    = err_r;
    if (byte_vld) begin
      count_nxt = last_byte ? 16'd0 : count_inc;
      if (count_r == 16'd0) begin
        // first byte: start a fresh capture
        nh_nxt     = 8'd0;
        hop_nxt    = 8'd0;
        ext_nxt    = 8'd0;
        port_nxt   = ingress_port;
        src_hi_nxt = '0;
        src_lo_nxt = '0;
        dst_hi_nxt = '0;
        dst_lo_nxt = '0;
        ol_nxt     = '0;
        skip_nxt   = 8'd0;
        phase_nxt  = OPT_PH_TYPE;
        err_nxt    = OPT_ERR_NONE;
      end else if (count_r == IDX_NEXT_HDR) begin
        nh_nxt = data_byte;
      end else if (count_r == IDX_HOP_LIMIT) begin
        hop_nxt = data_byte;
      end else if (count_r >= IDX_SRC_HI && count_r < IDX_SRC_LO) begin
        src_hi_nxt = {src_hi_r[55:0], data_byte};
      end else if (count_r >= IDX_SRC_LO && count_r < IDX_DST_HI) begin
        src_lo_nxt = {src_lo_r[55:0], data_byte};
      end else if (count_r >= IDX_DST_HI && count_r < IDX_DST_LO) begin
        dst_hi_nxt = {dst_hi_r[55:0], data_byte};
      end else if (count_r >= IDX_DST_LO && count_r < HDR_BYTES) begin
        dst_lo_nxt = {dst_lo_r[55:0], data_byte};
      end else if (count_r == IDX_EXT_LEN) begin
        ext_nxt = data_byte;
        if (nh_r == NH_HOP_BY_HOP) begin
          // (len + 1) * 8 - 2 bytes of option space
          ol_nxt    = {data_byte, 3'b110};
          phase_nxt = OPT_PH_TYPE;
          err_nxt   = OPT_ERR_NONE;
        end
      end else if (count_r >= IDX_OPTIONS && nh_r == NH_HOP_BY_HOP &&
                   err_r == OPT_ERR_NONE) begin
        unique case (phase_r) inside
          OPT_PH_TYPE: begin
            if (ol_r != 11'd0) begin
              if (data_byte == OPT_PAD1) begin
                ol_nxt = ol_r - 11'd1;
              end else if (ol_r < 11'd2) begin
                err_nxt = OPT_ERR_MALFORMED;
                ol_nxt  = '0;
              end else if (data_byte != OPT_PADN && data_byte[7:6] != 2'b00) begin
                phase_nxt = OPT_PH_LEN_DISCARD;
              end else begin
                phase_nxt = OPT_PH_LEN_PLAIN;
              end
            end
          end
          OPT_PH_LEN_PLAIN, OPT_PH_LEN_DISCARD: begin
            if ({2'b00, need} > ol_r) begin
              err_nxt   = OPT_ERR_MALFORMED;
              ol_nxt    = '0;
              phase_nxt = OPT_PH_TYPE;
            end else begin
              ol_nxt = ol_r - {2'b00, need};
              if (phase_r == OPT_PH_LEN_DISCARD) begin
                err_nxt   = OPT_ERR_DISCARD;
                phase_nxt = OPT_PH_TYPE;
              end else if (data_byte != 8'd0) begin
                skip_nxt  = data_byte;
                phase_nxt = OPT_PH_SKIP;
              end else begin
                phase_nxt = OPT_PH_TYPE;
              end
            end
          end
          OPT_PH_SKIP: begin
            skip_nxt = skip_dec;
            if (skip_dec == 8'd0) begin
              phase_nxt = OPT_PH_TYPE;
            end
          end
          default: begin
            phase_nxt = OPT_PH_TYPE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      nh_r     <= '0;
      hop_r    <= '0;
      ext_r    <= '0;
      port_r   <= '0;
      src_hi_r <= '0;
      src_lo_r <= '0;
      dst_hi_r <= '0;
      dst_lo_r <= '0;
      ol_r     <= '0;
      skip_r   <= '0;
      phase_r  <= OPT_PH_TYPE;
      err_r    <= OPT_ERR_NONE;
    end else begin
      count_r  <= count_nxt;
      nh_r     <= nh_nxt;
      hop_r    <= hop_nxt;
      ext_r    <= ext_nxt;
      port_r   <= port_nxt;
      src_hi_r <= src_hi_nxt;
      src_lo_r <= src_lo_nxt;
      dst_hi_r <= dst_hi_nxt;
      dst_lo_r <= dst_lo_nxt;
      ol_r     <= ol_nxt;
      skip_r   <= skip_nxt;
      phase_r  <= phase_nxt;
      err_r    <= err_nxt;
    end
  end

  assign rec_vld         = byte_vld && last_byte;
  assign rec.byte_count  = count_inc;
  assign rec.hop_limit   = hop_nxt;
  assign rec.next_header = nh_nxt;
  assign rec.ext_len     = ext_nxt;
  assign rec.opt_err     = err_nxt;
  assign rec.src_hi      = src_hi_nxt;
  assign rec.src_lo      = src_lo_nxt;
  assign rec.dst_hi      = dst_hi_nxt;
  assign rec.dst_lo      = dst_lo_nxt;
  assign rec.port        = port_nxt;

endmodule

`default_nettype wire

// ===== rtl/core/imf_queue.sv =====
// ----------------------------------------------------------------------------
// imf_queue: packet summary queue
// Short FIFO of packet records between the parser and the verdict stage.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire imf_pkg::pkt_rec_t wr_rec,
  input  wire logic              rd_en,
  output imf_pkg::pkt_rec_t      rd_rec,
  output logic                   q_full,
  output logic                   q_empty
);
  import imf_pkg::*;

  pkt_rec_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_wr, do_rd;

  assign q_full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_rec  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/imf_verdict.sv =====
// ----------------------------------------------------------------------------
// imf_verdict: verdict stage
// Applies the ordered checks to a packet summary and holds the result in
// the output register until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_verdict (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire imf_pkg::pkt_rec_t head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [3:0]             verdict,
  output logic [7:0]             new_hop_limit,
  output logic [63:0]            dest_high,
  output logic [63:0]            dest_low,
  output logic [63:0]            source_high,
  output logic [63:0]            source_low,
  output logic [7:0]             arrival_port,
  output logic [15:0]            packet_length
);
  import imf_pkg::*;

  logic        vld_r;
  logic        load;
  verdict_t    vd;
  logic [16:0] hbh_end;
  logic [3:0]  vd_r;
  logic [7:0]  hop_r;
  logic [63:0] dst_hi_r, dst_lo_r, src_hi_r, src_lo_r;
  logic [7:0]  port_r;
  logic [15:0] len_r;

  // header plus (len + 1) * 8 bytes of hop-by-hop header
  assign hbh_end = {1'b0, HDR_BYTES} + {6'd0, head.ext_len, 3'b000} + EXT_UNIT;

  always_comb begin
    if (head.byte_count < HDR_BYTES) begin
      vd = VERDICT_SHORT;
    end else if (head.hop_limit <= 8'd1) begin
      vd = VERDICT_HOP;
    end else if (head.dst_hi[63:56] != MCAST_PREFIX) begin
      vd = VERDICT_DST_UCAST;
    end else if (head.src_hi[63:56] == MCAST_PREFIX ||
                 (head.src_hi == '0 && head.src_lo == '0) ||
                 head.src_hi[63:54] == LLOCAL_PREFIX) begin
      vd = VERDICT_BAD_SRC;
    end else if ((head.dst_hi[51:48] & SCOPE_MASK) == 4'd0) begin
      vd = VERDICT_SCOPE;
    end else if (head.next_header != NH_HOP_BY_HOP) begin
      vd = VERDICT_FORWARD;
    end else if (head.byte_count < HBH_MIN_BYTES ||
                 {1'b0, head.byte_count} < hbh_end) begin
      vd = VERDICT_EXT_TRUNC;
    end else if (head.opt_err == OPT_ERR_MALFORMED) begin
      vd = VERDICT_EXT_MALF;
    end else if (head.opt_err == OPT_ERR_DISCARD) begin
      vd = VERDICT_OPT_DROP;
    end else begin
      vd = VERDICT_FORWARD;
    end
  end

  // refill the output register when it is free or being drained
  assign load  = !q_empty && (!vld_r || pop);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (pop) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vd_r     <= vd;
      hop_r    <= (vd == VERDICT_FORWARD) ? head.hop_limit - 8'd1 : head.hop_limit;
      dst_hi_r <= head.dst_hi;
      dst_lo_r <= head.dst_lo;
      src_hi_r <= head.src_hi;
      src_lo_r <= head.src_lo;
      port_r   <= head.port;
      len_r    <= head.byte_count;
    end
  end

  assign empty         = !vld_r;
  assign verdict       = vd_r;
  assign new_hop_limit = hop_r;
  assign dest_high     = dst_hi_r;
  assign dest_low      = dst_lo_r;
  assign source_high   = src_hi_r;
  assign source_low    = src_lo_r;
  assign arrival_port  = port_r;
  assign packet_length = len_r;

endmodule

`default_nettype wire

// ===== rtl/core/ipv6_multicast_ingress_filter.sv =====
// ----------------------------------------------------------------------------
// ipv6_multicast_ingress_filter: IPv6 multicast ingress header filter
// Byte-wide IPv6 header and hop-by-hop option check with one verdict per
// packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_data_byte, in_last_byte and in_ingress_port with
//   push high; a byte is taken at each clock edge where push is high and
//   full is low. in_ingress_port is sampled on the first byte of a packet.
//   The byte after a last byte starts the next packet.
//   Result queue: one result per packet. While empty is low the result
//   fields are valid; pulse pop to take it.
//   Throughput: one byte per cycle while full is low; the parser updates its
//   capture and option-walk registers once per byte.
//   Result path: the summary enters the queue on the edge that takes its last
//   byte and loads the verdict register from there once that register is
//   free or being popped.
//   Stalls: two packet summaries queue behind the output register; full
//   is high while both queue entries are occupied and holds every input
//   byte; it falls right after the edge at which the output is popped.
//   Reset (rst_n low, synchronous) empties both queues and clears the byte
//   counter, so the next byte is the first byte of a packet.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_multicast_ingress_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [7:0]  in_ingress_port,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       out_verdict,
  output logic [7:0]       out_new_hop_limit,
  output logic [63:0]      out_dest_high,
  output logic [63:0]      out_dest_low,
  output logic [63:0]      out_source_high,
  output logic [63:0]      out_source_low,
  output logic [7:0]       out_arrival_port,
  output logic [15:0]      out_packet_length
);
  import imf_pkg::*;

  pkt_rec_t  wr_rec, head;
  logic      rec_vld, byte_vld, q_full, q_empty, q_pop;

  assign byte_vld = push && !full;
  assign full     = q_full;

  imf_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_vld     (byte_vld),
    .data_byte    (in_data_byte),
    .last_byte    (in_last_byte),
    .ingress_port (in_ingress_port),
    .rec          (wr_rec),
    .rec_vld      (rec_vld)
  );

  imf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_vld),
    .wr_rec  (wr_rec),
    .rd_en   (q_pop),
    .rd_rec  (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  imf_verdict u_verdict (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .verdict       (out_verdict),
    .new_hop_limit (out_new_hop_limit),
    .dest_high     (out_dest_high),
    .dest_low      (out_dest_low),
    .source_high   (out_source_high),
    .source_low    (out_source_low),
    .arrival_port  (out_arrival_port),
    .packet_length (out_packet_length)
  );

endmodule

`default_nettype wire

// ===== rtl/core/imf_checker.sv =====
// ----------------------------------------------------------------------------
// imf_checker: port-level checks of the multicast ingress filter
// Watches the result queue for reset behavior, stall holding and
// verdict consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module imf_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [3:0]  out_verdict,
  input  wire logic [7:0]  out_new_hop_limit,
  input  wire logic [63:0] out_dest_high,
  input  wire logic [15:0] out_packet_length
);
  import imf_pkg::*;

  // reset drains the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // a stalled transaction keeps its verdict and length
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_verdict) &&
                          $stable(out_packet_length)))
    else $error("stalled result changed");

  // short verdict exactly when fewer than a header's worth of bytes arrived
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_verdict == VERDICT_SHORT) == (out_packet_length < HDR_BYTES)))
    else $error("short verdict does not match packet length");

  // a forwarded packet is multicast with a live, decremented hop limit
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_verdict == VERDICT_FORWARD) |->
      (out_dest_high[63:56] == MCAST_PREFIX && out_new_hop_limit != 8'd0 &&
       out_packet_length >= HDR_BYTES))
    else $error("forwarded packet fails header checks");

endmodule

bind ipv6_multicast_ingress_filter imf_checker u_imf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .empty             (empty),
  .pop               (pop),
  .out_verdict       (out_verdict),
  .out_new_hop_limit (out_new_hop_limit),
  .out_dest_high     (out_dest_high),
  .out_packet_length (out_packet_length)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: packet-level check of the IPv6 multicast ingress filter
// Feeds packets byte by byte through the input queue and predicts each
// verdict record with a byte-accurate copy of the filter. It starts with a
// table of directed packets covering every verdict and boundary, then sends
// random packets, mostly well-formed hop-by-hop option chains. Both queue
// sides idle at random.
// ----------------------------------------------------------------------------

module tb;
  import imf_pkg::*;

  localparam int          QUIET_LIMIT = 2000;
  localparam logic [7:0]  NH_NONE     = 8'd59;

  localparam logic [63:0] SRC_HI      = 64'h2001_0db8_0000_0001;
  localparam logic [63:0] SRC_LO      = 64'h0000_0000_0000_0002;
  localparam logic [63:0] GRP_HI      = 64'hff0e_0000_0000_0000;
  localparam logic [63:0] GRP_LO      = 64'h0000_0000_0000_0101;
  localparam logic [63:0] ONES        = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] MC_SRC_HI   = 64'hff02_0000_0000_0000;
  localparam logic [63:0] LL_HI       = 64'hfe80_0000_0000_0000;
  localparam logic [63:0] LL_TOP_HI   = 64'hfebf_ffff_ffff_ffff;
  localparam logic [63:0] SITE_HI     = 64'hfec0_0000_0000_0001;
  localparam logic [63:0] SCOPE3_HI   = 64'hff03_0000_0000_0000;
  localparam logic [63:0] SCOPE4_HI   = 64'hff04_0000_0000_0000;
  localparam logic [63:0] MAX_SRC_HI  = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  hop_limit;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [7:0]  port;
    logic [15:0] length;
  } filt_res_t;

  // One directed packet: header fields, hop-by-hop length byte and the first
  // six option bytes; everything past them is zero.
  typedef struct packed {
    logic [31:0] len;
    logic [7:0]  port;
    logic [7:0]  nh;
    logic [7:0]  hop;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [7:0]  ext;
    logic [47:0] opts;
    logic        pinned;
    verdict_t    verdict;
  } dir_row_t;

  localparam int N_DIR = 26;

  // len, port, nh, hop, src hi/lo, dst hi/lo, ext len, options, pinned, verdict
  dir_row_t dir_rows [N_DIR] = '{
    '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, VERDICT_SHORT},
    '{39, 255, NH_NONE, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_SHORT},
    '{40, 255, NH_NONE, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_FORWARD},
    '{40, 1, NH_NONE, 0, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_HOP},
    '{40, 2, NH_NONE, 1, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_HOP},
    '{40, 3, NH_NONE, 255, SRC_HI, SRC_LO, 0, 0, 0, 0, 1, VERDICT_DST_UCAST},
    '{48, 4, NH_NONE, 255, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_FORWARD},
    '{40, 5, NH_NONE, 64, MC_SRC_HI, 1, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_BAD_SRC},
    '{40, 6, NH_NONE, 64, 0, 0, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_BAD_SRC},
    '{40, 7, NH_NONE, 64, LL_HI, 1, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_BAD_SRC},
    '{40, 8, NH_NONE, 64, LL_TOP_HI, ONES, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_BAD_SRC},
    '{40, 9, NH_NONE, 64, SITE_HI, 0, GRP_HI, GRP_LO, 0, 0, 0, VERDICT_FORWARD},
    '{40, 10, NH_NONE, 64, SRC_HI, SRC_LO, SCOPE3_HI, 1, 0, 0, 1, VERDICT_SCOPE},
    '{40, 11, NH_NONE, 64, SRC_HI, SRC_LO, SCOPE4_HI, 1, 0, 0, 0, VERDICT_FORWARD},
    '{41, 12, NH_HOP_BY_HOP, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0, 0,
      1, VERDICT_EXT_TRUNC},
    '{55, 13, NH_HOP_BY_HOP, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 1, 0,
      1, VERDICT_EXT_TRUNC},
    '{48, 14, NH_HOP_BY_HOP, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0,
      48'h01_04_00_00_00_00, 1, VERDICT_FORWARD},
    '{48, 15, NH_HOP_BY_HOP, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0,
      48'h00_00_00_00_00_05, 1, VERDICT_EXT_MALF},
    '{48, 16, NH_HOP_BY_HOP, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0,
      48'h05_09_00_00_00_00, 1, VERDICT_EXT_MALF},
    '{48, 17, NH_HOP_BY_HOP, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0,
      48'hc2_04_00_00_00_00, 1, VERDICT_OPT_DROP},
    '{48, 18, NH_HOP_BY_HOP, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0,
      48'h40_00_05_09_00_00, 1, VERDICT_OPT_DROP},
    '{48, 19, NH_HOP_BY_HOP, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0,
      48'hff_04_00_00_00_00, 1, VERDICT_OPT_DROP},
    '{100, 255, NH_HOP_BY_HOP, 64, MAX_SRC_HI, ONES, ONES, ONES, 255, 0,
      1, VERDICT_EXT_TRUNC},
    '{45, 20, NH_HOP_BY_HOP, 1, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_HOP},
    '{40, 21, NH_NONE, 2, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0, 0, 1, VERDICT_FORWARD},
    '{60, 22, NH_HOP_BY_HOP, 64, SRC_HI, SRC_LO, GRP_HI, GRP_LO, 0,
      48'h01_00_01_00_00_00, 0, VERDICT_FORWARD}
  };

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic [7:0]  in_ingress_port;
  logic        empty;
  logic        pop;
  logic [3:0]  out_verdict;
  logic [7:0]  out_new_hop_limit;
  logic [63:0] out_dest_high;
  logic [63:0] out_dest_low;
  logic [63:0] out_source_high;
  logic [63:0] out_source_low;
  logic [7:0]  out_arrival_port;
  logic [15:0] out_packet_length;

  // Predicted filter state
  logic [15:0] pk_count = '0;
  logic [7:0]  pk_hop;
  logic [7:0]  pk_nh;
  logic [7:0]  pk_ext;
  logic [63:0] pk_src_hi;
  logic [63:0] pk_src_lo;
  logic [63:0] pk_dst_hi;
  logic [63:0] pk_dst_lo;
  logic [10:0] pk_opt_left;
  opt_phase_t  pk_phase;
  logic [7:0]  pk_skip;
  opt_err_t    pk_err;
  logic [7:0]  pk_port;

  filt_res_t   expected_results[$];
  logic [7:0]  pkt_bytes[$];
  logic        calm = 1'b0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  ipv6_multicast_ingress_filter dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append one byte to the packet under construction.
  function automatic void add_byte(input logic [7:0] b);
    pkt_bytes.insert(pkt_bytes.size(), b);
  endfunction

  // Advance the filter by one byte; returns the verdict record on a last byte.
  function automatic void filter_step(input logic [7:0] b, input logic lastb,
                                      input logic [7:0] port, output logic got,
                                      output filt_res_t r);
    logic [15:0] idx;
    int unsigned need;
    verdict_t    v;
    idx = pk_count;
    got = 1'b0;
    r = '0;
    if (idx == 16'd0) begin
      pk_hop = '0;
      pk_nh = '0;
      pk_ext = '0;
      pk_src_hi = '0;
      pk_src_lo = '0;
      pk_dst_hi = '0;
      pk_dst_lo = '0;
      pk_opt_left = '0;
      pk_phase = OPT_PH_TYPE;
      pk_skip = '0;
      pk_err = OPT_ERR_NONE;
      pk_port = port;
    end
    if (idx == IDX_NEXT_HDR) begin
      pk_nh = b;
    end else if (idx == IDX_HOP_LIMIT) begin
      pk_hop = b;
    end else if (idx >= IDX_SRC_HI && idx < IDX_SRC_LO) begin
      pk_src_hi = {pk_src_hi[55:0], b};
    end else if (idx >= IDX_SRC_LO && idx < IDX_DST_HI) begin
      pk_src_lo = {pk_src_lo[55:0], b};
    end else if (idx >= IDX_DST_HI && idx < IDX_DST_LO) begin
      pk_dst_hi = {pk_dst_hi[55:0], b};
    end else if (idx >= IDX_DST_LO && idx < HDR_BYTES) begin
      pk_dst_lo = {pk_dst_lo[55:0], b};
    end else if (idx == IDX_EXT_LEN) begin
      pk_ext = b;
      if (pk_nh == NH_HOP_BY_HOP) begin
        pk_opt_left = 11'((int'(b) + 1) * int'(EXT_UNIT) - 2);
        pk_phase = OPT_PH_TYPE;
        pk_err = OPT_ERR_NONE;
      end
    end else if (idx >= IDX_OPTIONS && pk_nh == NH_HOP_BY_HOP
                 && pk_err == OPT_ERR_NONE) begin
      // Walk the option region; the first error freezes it.
      case (pk_phase)
        OPT_PH_TYPE: begin
          if (pk_opt_left != 0) begin
            if (b == OPT_PAD1) begin
              pk_opt_left--;
            end else if (pk_opt_left < 2) begin
              pk_err = OPT_ERR_MALFORMED;
              pk_opt_left = '0;
            end else begin
              pk_phase = (b != OPT_PADN && b[7:6] != 2'b00) ? OPT_PH_LEN_DISCARD
                                                          : OPT_PH_LEN_PLAIN;
            end
          end
        end
        OPT_PH_LEN_PLAIN, OPT_PH_LEN_DISCARD: begin
          need = int'(b) + 2;
          if (need > pk_opt_left) begin
            pk_err = OPT_ERR_MALFORMED;
            pk_opt_left = '0;
            pk_phase = OPT_PH_TYPE;
          end else begin
            pk_opt_left -= 11'(need);
            if (pk_phase == OPT_PH_LEN_DISCARD) begin
              pk_err = OPT_ERR_DISCARD;
              pk_phase = OPT_PH_TYPE;
            end else if (b != 0) begin
              pk_skip = b;
              pk_phase = OPT_PH_SKIP;
            end else begin
              pk_phase = OPT_PH_TYPE;
            end
          end
        end
        default: begin
          if (pk_skip != 0) pk_skip--;
          if (pk_skip == 0) pk_phase = OPT_PH_TYPE;
        end
      endcase
    end

    if (pk_count != CNT_MAX) pk_count++;

    if (lastb) begin
      if (pk_count < HDR_BYTES) v = VERDICT_SHORT;
      else if (pk_hop <= 8'd1) v = VERDICT_HOP;
      else if (pk_dst_hi[63:56] != MCAST_PREFIX) v = VERDICT_DST_UCAST;
      else if (pk_src_hi[63:56] == MCAST_PREFIX || {pk_src_hi, pk_src_lo} == '0
               || pk_src_hi[63:54] == LLOCAL_PREFIX) v = VERDICT_BAD_SRC;
      else if ((pk_dst_hi[51:48] & SCOPE_MASK) == 4'd0) v = VERDICT_SCOPE;
      else if (pk_nh == NH_HOP_BY_HOP && (pk_count < HBH_MIN_BYTES
               || int'(pk_count) < int'(HDR_BYTES)
                                   + (int'(pk_ext) + 1) * int'(EXT_UNIT)))
        v = VERDICT_EXT_TRUNC;
      else if (pk_nh == NH_HOP_BY_HOP && pk_err == OPT_ERR_MALFORMED) v = VERDICT_EXT_MALF;
      else if (pk_nh == NH_HOP_BY_HOP && pk_err == OPT_ERR_DISCARD) v = VERDICT_OPT_DROP;
      else v = VERDICT_FORWARD;
      got = 1'b1;
      r.verdict = v;
      r.hop_limit = (v == VERDICT_FORWARD) ? pk_hop - 8'd1 : pk_hop;
      r.dst_hi = pk_dst_hi;
      r.dst_lo = pk_dst_lo;
      r.src_hi = pk_src_hi;
      r.src_lo = pk_src_lo;
      r.port = pk_port;
      r.length = pk_count;
      pk_count = '0;
    end
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
    end
  endfunction

  // Lay out a 40-byte IPv6 header in pkt_bytes.
  task automatic put_header(input logic [7:0] nh, input logic [7:0] hop,
                            input logic [63:0] sh, input logic [63:0] sl,
                            input logic [63:0] dh, input logic [63:0] dl);
    logic [255:0] addrs;
    int k;
    addrs = {sh, sl, dh, dl};
    pkt_bytes.delete();
    add_byte(8'h60);
    for (k = 1; k < 6; k++) add_byte(8'($urandom));
    add_byte(nh);
    add_byte(hop);
    for (k = 31; k >= 0; k--) add_byte(addrs[8*k +: 8]);
  endtask

  // Push pkt_bytes through the input queue, one transaction per byte.
  task automatic send_packet(input logic [7:0] port, input logic pinned,
                             input verdict_t pin_verdict);
    int unsigned i;
    int unsigned last_i;
    logic [7:0]  drv_port;
    logic        got;
    filt_res_t   r;
    last_i = pkt_bytes.size() - 1;
    for (i = 0; i <= last_i; i++) begin
      if (!calm) begin
        while ($urandom_range(0, 99) < 18) begin
          push <= 1'b0;
          @(posedge clk);
        end
      end
      drv_port = (i == 0) ? port : 8'($urandom);
      push <= 1'b1;
      in_data_byte <= pkt_bytes[i];
      in_last_byte <= (i == last_i);
      in_ingress_port <= drv_port;
      do @(posedge clk); while (full);
      filter_step(pkt_bytes[i], i == last_i, drv_port, got, r);
      if (got) begin
        if (pinned) r.verdict = pin_verdict;
        expected_results.insert(expected_results.size(), r);
      end
    end
  endtask

  // Result side: check each popped transaction, then pick the next pop.
  initial begin
    filt_res_t want;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no packet pending, expected none, got verdict %0d",
                   $time, out_verdict);
        end else begin
          want = expected_results.pop_front();
          check_field("verdict", want.verdict, out_verdict);
          check_field("new_hop_limit", want.hop_limit, out_new_hop_limit);
          check_field("dest_high", want.dst_hi, out_dest_high);
          check_field("dest_low", want.dst_lo, out_dest_low);
          check_field("source_high", want.src_hi, out_source_high);
          check_field("source_low", want.src_lo, out_source_low);
          check_field("arrival_port", want.port, out_arrival_port);
          check_field("packet_length", want.length, out_packet_length);
        end
      end
      pop <= rst_n && (calm || $urandom_range(0, 99) >= 18);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("ipv6_multicast_ingress_filter: mismatch");
      $finish;
    end
  end

  initial begin
    int          i;
    int          k;
    int          span;
    int          rem;
    int          cap;
    int          olen;
    int          pick;
    int          n;
    int unsigned rnd_bytes;
    int unsigned rnd_pkts;
    logic [7:0]  nh;
    logic [7:0]  hop;
    logic [7:0]  ext;
    logic [7:0]  otype;
    logic [63:0] sh;
    logic [63:0] sl;
    logic [63:0] dh;
    logic [63:0] dl;

    rst_n <= 1'b0;
    push <= 1'b0;
    in_data_byte <= '0;
    in_last_byte <= 1'b0;
    in_ingress_port <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      put_header(dir_rows[i].nh, dir_rows[i].hop, dir_rows[i].src_hi,
                 dir_rows[i].src_lo, dir_rows[i].dst_hi, dir_rows[i].dst_lo);
      add_byte(NH_NONE);
      add_byte(dir_rows[i].ext);
      for (k = 5; k >= 0; k--) add_byte(dir_rows[i].opts[8*k +: 8]);
      while (pkt_bytes.size() < dir_rows[i].len) add_byte(8'h00);
      if (pkt_bytes.size() > dir_rows[i].len)
        pkt_bytes = pkt_bytes[0:dir_rows[i].len - 1];
      send_packet(dir_rows[i].port, dir_rows[i].pinned, dir_rows[i].verdict);
    end

    rnd_bytes = 0;
    rnd_pkts = 0;
    while (rnd_bytes < 450 || rnd_pkts < 6) begin
      // Hold both sides busy for a stretch in the middle.
      calm <= (rnd_bytes >= 100 && rnd_bytes < 300);
      if ($urandom_range(0, 19) == 0) begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end else begin
        hop = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 2))
                                          : 8'($urandom_range(2, 255));
        sl = {$urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          sh = {MCAST_PREFIX, 56'({$urandom, $urandom})};
        end else if (pick == 1) begin
          sh = '0;
          sl = '0;
        end else if (pick == 2) begin
          sh = {LLOCAL_PREFIX, 54'({$urandom, $urandom})};
        end else begin
          sh = {$urandom, $urandom};
          if (sh[63:56] == MCAST_PREFIX || sh[63:54] == LLOCAL_PREFIX) sh[63] = 1'b0;
        end
        dh = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                         : {MCAST_PREFIX, 56'({$urandom, $urandom})};
        dl = {$urandom, $urandom};
        nh = ($urandom_range(0, 4) < 3) ? NH_HOP_BY_HOP : 8'($urandom);
        put_header(nh, hop, sh, sl, dh, dl);
        if (nh == NH_HOP_BY_HOP) begin
          pick = $urandom_range(0, 19);
          ext = (pick < 17) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(4, 15));
          span = (int'(ext) + 1) * int'(EXT_UNIT) - 2;
          add_byte(8'($urandom));
          add_byte(ext);
          if ($urandom_range(0, 9) == 0) begin
            repeat (span) add_byte(8'($urandom));
          end else begin
            rem = span;
            while (rem > 0) begin
              pick = $urandom_range(0, 9);
              if (rem == 1 || pick < 3) begin
                add_byte(OPT_PAD1);
                rem--;
              end else begin
                cap = ($urandom_range(0, 7) == 0) ? 255 : 12;
                if (cap > rem - 2) cap = rem - 2;
                olen = $urandom_range(0, cap);
                if (pick < 5) otype = OPT_PADN;
                else if (pick < 9) otype = 8'($urandom_range(2, 63));
                else otype = {2'($urandom_range(1, 3)), 6'($urandom)};
                add_byte(otype);
                add_byte(8'(olen));
                repeat (olen) add_byte(8'($urandom));
                rem -= olen + 2;
              end
            end
            // Break a well-formed chain now and then.
            if ($urandom_range(0, 9) == 0)
              pkt_bytes[42 + $urandom_range(0, span - 1)] = 8'($urandom);
          end
        end
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : 0;
        repeat (n) add_byte(8'($urandom));
        if ($urandom_range(0, 11) == 0)
          pkt_bytes = pkt_bytes[0:$urandom_range(1, pkt_bytes.size()) - 1];
      end
      rnd_bytes += pkt_bytes.size();
      rnd_pkts++;
      send_packet(8'($urandom), 1'b0, VERDICT_FORWARD);
    end
    push <= 1'b0;
    calm <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("ipv6_multicast_ingress_filter: match");
    else
      $display("ipv6_multicast_ingress_filter: mismatch");
    $finish;
  end

endmodule
